FILE: rtl/gcl_pkg.sv
package gcl_pkg;

    // Grid limits and number format.
    localparam int AXIS_MAX   = 64;
    localparam int AXIS_BITS  = $clog2(AXIS_MAX);
    localparam int VALUE_BITS = 32;
    localparam int CNT_BITS   = 7;
    localparam int NH_BITS    = 2 * CNT_BITS;
    localparam int TOT_BITS   = 3 * CNT_BITS;
    localparam int TBL_DEPTH  = 3 * AXIS_MAX;
    localparam int TBL_ABITS  = $clog2(TBL_DEPTH);
    localparam int SURF_DEPTH = 4096;
    localparam int SURF_ABITS = $clog2(SURF_DEPTH);
    localparam int COL_BITS   = 12;
    localparam int IDX_BITS   = 6;
    localparam int FIELD_BITS = 32;

    // Divider sizing: the dividend is a linear cell number.
    localparam int DIV_N_BITS   = 18;
    localparam int DIV_CNT_BITS = $clog2(DIV_N_BITS);

    // Stream packing.
    localparam int IN_SLOT_BITS   = 12;
    localparam int IN_SLOT_LSB    = 0;
    localparam int IN_VALUE_LSB   = IN_SLOT_LSB + IN_SLOT_BITS;
    localparam int IN_CELL_LSB    = IN_VALUE_LSB + FIELD_BITS;
    localparam int IN_FIELD_BITS  = IN_CELL_LSB + DIV_N_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int IN_TUSER_BITS  = 4;
    localparam int OUT_FIELD_BITS = 3 * IDX_BITS + COL_BITS + 6 * FIELD_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

    // Configuration port.
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_NX       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NY       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_NZ       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_ORIGIN = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_ORIGIN = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_Z_ORIGIN = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SURF_EN  = 3'd6;

    // Request function codes and axis codes.
    localparam logic [1:0] FN_WIDTH = 2'd0;
    localparam logic [1:0] FN_SURF  = 2'd1;
    localparam logic [1:0] FN_QUERY = 2'd2;
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef logic signed [VALUE_BITS-1:0] val_t;
    typedef logic [CNT_BITS-1:0] cnt_t;

    localparam val_t VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam val_t VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    // Divider request and response.
    typedef struct packed {
        logic                  start;
        logic [DIV_N_BITS-1:0] dividend;
        logic [NH_BITS-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIV_N_BITS-1:0] quotient;
        logic [NH_BITS-1:0]    remainder;
    } div_rsp_t;

    // Saturating signed addition.
    function automatic val_t sat_add(val_t a, val_t b);
        logic signed [VALUE_BITS:0] s;
        s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
        if (s[VALUE_BITS] != s[VALUE_BITS-1])
        begin
            sat_add = s[VALUE_BITS] ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            sat_add = s[VALUE_BITS-1:0];
        end
    endfunction

    // A count register is limited to the table size.
    function automatic cnt_t eff_count(cnt_t c);
        eff_count = (c > CNT_BITS'(AXIS_MAX)) ? CNT_BITS'(AXIS_MAX) : c;
    endfunction

    // Tables are laid out axis-major.
    function automatic logic [TBL_ABITS-1:0] tbl_addr(logic [1:0] axis,
                                                      logic [AXIS_BITS-1:0] idx);
        tbl_addr = TBL_ABITS'(axis) * TBL_ABITS'(AXIS_MAX) + TBL_ABITS'(idx);
    endfunction

endpackage

FILE: rtl/grid_cell_locator.sv
// Locator for a rectilinear 3D grid in Q16.16 signed fixed point. Each request on the input
// stream is a width load, a surface load or a query, chosen by the function code in tuser.
// Width loads for one axis must come in ascending slot order: slot 0 restarts that axis's
// running edge at its origin, and every load stores the cell center (edge plus half the
// width, half taken by an arithmetic shift) and the width, then moves the edge on by the
// width; all additions saturate. A surface load stores one offset per column. A query
// turns a linear cell number into x, y and z indices and a column index and returns the
// centers and widths, with the column's surface offset added to the z center when enabled;
// a number outside the grid returns valid_res 0 and all other fields 0. Loads give no
// result. A surface load is written as it is taken and a width load passes the center and
// edge states; a query spends most of its time in one divider (skipped when the number lies
// outside the grid) that produces one quotient bit per cycle and runs twice per query, by
// nx*ny and then by nx. The three tables are single-port-read RAMs, so the six table words
// of a query are fetched one axis at a time. The block takes no new request while it works
// on one; a finished result sits in an output register, so loads are taken while it waits.
// Configuration must be written only while the block is idle; nothing here enforces it.
module grid_cell_locator (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata, from bit 0: slot (12), value (32), cell_number (18), zero fill (2).
    input  logic [gcl_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    // tuser, from bit 0: func (2), axis (2).
    input  logic [gcl_pkg::IN_TUSER_BITS-1:0]  s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata, from bit 0: index_x (6), index_y (6), index_z (6), column (12), center_x,
    // center_y, center_z, width_x, width_y, width_z (32 each), zero fill (2).
    output logic [gcl_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    // tuser: valid_res (1).
    output logic                               m_axis_tuser,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [gcl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [gcl_pkg::FIELD_BITS-1:0]     cfg_data
);

    import gcl_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_LOAD_CTR  = 13'b0000000000010,
        S_LOAD_EDGE = 13'b0000000000100,
        S_QSIZE     = 13'b0000000001000,
        S_QTOTAL    = 13'b0000000010000,
        S_DIV1      = 13'b0000000100000,
        S_DIV2      = 13'b0000001000000,
        S_RD_X      = 13'b0000010000000,
        S_RD_Y      = 13'b0000100000000,
        S_RD_Z      = 13'b0001000000000,
        S_RD_LAST   = 13'b0010000000000,
        S_SURF      = 13'b0100000000000,
        S_FINISH    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    cnt_t nx_reg, ny_reg, nz_reg;
    val_t x_origin_reg, y_origin_reg, z_origin_reg;
    logic surf_en_reg;

    // Request fields as they arrive.
    logic [1:0]              in_func, in_axis;
    logic [IN_SLOT_BITS-1:0] in_slot;
    val_t                    in_value;
    logic [DIV_N_BITS-1:0]   in_cell;
    logic                    accept;

    // Captured request.
    logic [1:0]              axis_reg;
    logic [AXIS_BITS-1:0]    slot_reg;
    val_t                    value_reg;
    logic [DIV_N_BITS-1:0]   cell_reg;

    // Running edges, one per axis.
    val_t edge_reg [3];
    val_t edge_base;
    val_t origin_sel;

    // Query working registers.
    logic [NH_BITS-1:0]  nh_reg;
    logic [TOT_BITS-1:0] total;
    logic                in_grid;
    logic                in_grid_reg;
    logic [IDX_BITS-1:0] ix_reg, iy_reg, iz_reg;
    logic [COL_BITS-1:0] col_reg;
    val_t                cx_reg, cy_reg, cz_reg, wx_reg, wy_reg, wz_reg, surf_reg;

    // Shared saturating adder.
    val_t add_a, add_b, add_sum;

    // Divider.
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Tables.
    logic                 tbl_we;
    logic [TBL_ABITS-1:0] tbl_waddr, tbl_raddr;
    val_t                 ctr_rdata, wid_rdata, surf_rdata;
    logic                 surf_we;

    // Output register.
    logic                      m_valid_reg, m_valid_next;
    logic                      out_load;
    logic [OUT_TDATA_BITS-1:0] out_data_reg;
    logic                      out_user_reg;

    assign in_func  = s_axis_tuser[1:0];
    assign in_axis  = s_axis_tuser[3:2];
    assign in_slot  = s_axis_tdata[IN_SLOT_LSB +: IN_SLOT_BITS];
    assign in_value = s_axis_tdata[IN_VALUE_LSB +: FIELD_BITS];
    assign in_cell  = s_axis_tdata[IN_CELL_LSB +: DIV_N_BITS];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Slot 0 restarts the axis at its origin.
    always_comb
    begin
        case (axis_reg)
            AX_X:    origin_sel = x_origin_reg;
            AX_Y:    origin_sel = y_origin_reg;
            default: origin_sel = z_origin_reg;
        endcase
    end

    assign edge_base = (slot_reg == '0) ? origin_sel : edge_reg[axis_reg];

    // The adder serves the center, the edge update and the surface offset in turn.
    always_comb
    begin
        case (state_reg)
            S_LOAD_CTR:
            begin
                add_a = edge_base;
                add_b = value_reg >>> 1;
            end
            S_LOAD_EDGE:
            begin
                add_a = edge_reg[axis_reg];
                add_b = value_reg;
            end
            default:
            begin
                add_a = cz_reg;
                add_b = surf_reg;
            end
        endcase
    end

    assign add_sum = sat_add(add_a, add_b);

    assign total   = TOT_BITS'(nh_reg) * TOT_BITS'(eff_count(nz_reg));
    assign in_grid = (total != '0) && ({{(TOT_BITS-DIV_N_BITS){1'b0}}, cell_reg} < total);

    assign tbl_we    = (state_reg == S_LOAD_CTR);
    assign tbl_waddr = tbl_addr(axis_reg, slot_reg);
    assign surf_we   = accept && (in_func == FN_SURF);

    always_comb
    begin
        case (state_reg)
            S_RD_X:  tbl_raddr = tbl_addr(AX_X, ix_reg);
            S_RD_Y:  tbl_raddr = tbl_addr(AX_Y, iy_reg);
            default: tbl_raddr = tbl_addr(AX_Z, iz_reg);
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = cell_reg;
        div_req.divisor  = nh_reg;
        out_load         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((in_func == FN_WIDTH) && (in_axis <= AX_Z)
                        && (in_slot < IN_SLOT_BITS'(AXIS_MAX)))
                    begin
                        state_next = S_LOAD_CTR;
                    end
                    else if (in_func == FN_QUERY)
                    begin
                        state_next = S_QSIZE;
                    end
                end
            end
            S_LOAD_CTR:  state_next = S_LOAD_EDGE;
            S_LOAD_EDGE: state_next = S_IDLE;
            S_QSIZE:     state_next = S_QTOTAL;
            S_QTOTAL:
            begin
                if (in_grid)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIV1:
            begin
                // The column index is divided by nx right away.
                div_req.dividend = DIV_N_BITS'(div_rsp.remainder);
                div_req.divisor  = NH_BITS'(eff_count(nx_reg));
                if (div_rsp.done)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_RD_X;
                end
            end
            S_RD_X:    state_next = S_RD_Y;
            S_RD_Y:    state_next = S_RD_Z;
            S_RD_Z:    state_next = S_RD_LAST;
            S_RD_LAST: state_next = S_SURF;
            S_SURF:    state_next = S_FINISH;
            S_FINISH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg && !m_axis_tready;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg       <= cnt_t'(1);
            ny_reg       <= cnt_t'(1);
            nz_reg       <= cnt_t'(1);
            x_origin_reg <= '0;
            y_origin_reg <= '0;
            z_origin_reg <= '0;
            surf_en_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NX:       nx_reg       <= cfg_data[CNT_BITS-1:0];
                REG_NY:       ny_reg       <= cfg_data[CNT_BITS-1:0];
                REG_NZ:       nz_reg       <= cfg_data[CNT_BITS-1:0];
                REG_X_ORIGIN: x_origin_reg <= cfg_data;
                REG_Y_ORIGIN: y_origin_reg <= cfg_data;
                REG_Z_ORIGIN: z_origin_reg <= cfg_data;
                REG_SURF_EN:  surf_en_reg  <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Running edges.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg[0] <= '0;
            edge_reg[1] <= '0;
            edge_reg[2] <= '0;
        end
        else if (state_reg == S_LOAD_CTR)
        begin
            edge_reg[axis_reg] <= edge_base;
        end
        else if (state_reg == S_LOAD_EDGE)
        begin
            edge_reg[axis_reg] <= add_sum;
        end
    end

    // Request capture and query datapath.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            axis_reg  <= in_axis;
            slot_reg  <= in_slot[AXIS_BITS-1:0];
            value_reg <= in_value;
            cell_reg  <= in_cell;
        end
        if (state_reg == S_QSIZE)
        begin
            nh_reg <= NH_BITS'(eff_count(nx_reg)) * NH_BITS'(eff_count(ny_reg));
        end
        if (state_reg == S_QTOTAL)
        begin
            in_grid_reg <= in_grid;
        end
        if ((state_reg == S_DIV1) && div_rsp.done)
        begin
            iz_reg  <= div_rsp.quotient[IDX_BITS-1:0];
            col_reg <= div_rsp.remainder[COL_BITS-1:0];
        end
        if ((state_reg == S_DIV2) && div_rsp.done)
        begin
            iy_reg <= div_rsp.quotient[IDX_BITS-1:0];
            ix_reg <= div_rsp.remainder[IDX_BITS-1:0];
        end
        if (state_reg == S_RD_Y)
        begin
            cx_reg <= ctr_rdata;
            wx_reg <= wid_rdata;
        end
        if (state_reg == S_RD_Z)
        begin
            cy_reg <= ctr_rdata;
            wy_reg <= wid_rdata;
        end
        if (state_reg == S_RD_LAST)
        begin
            cz_reg   <= ctr_rdata;
            wz_reg   <= wid_rdata;
            surf_reg <= surf_rdata;
        end
        if ((state_reg == S_SURF) && surf_en_reg)
        begin
            cz_reg <= add_sum;
        end
        if (out_load)
        begin
            out_user_reg <= in_grid_reg;
            if (in_grid_reg)
            begin
                out_data_reg <= {{OUT_PAD_BITS{1'b0}}, wz_reg, wy_reg, wx_reg,
                                 cz_reg, cy_reg, cx_reg, col_reg, iz_reg, iy_reg, ix_reg};
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    gcl_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gcl_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TBL_DEPTH)
    ) u_center_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (add_sum),
        .raddr (tbl_raddr),
        .rdata (ctr_rdata)
    );

    gcl_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TBL_DEPTH)
    ) u_width_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (value_reg),
        .raddr (tbl_raddr),
        .rdata (wid_rdata)
    );

    gcl_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SURF_DEPTH)
    ) u_surface_ram (
        .clk   (clk),
        .we    (surf_we),
        .waddr (in_slot[SURF_ABITS-1:0]),
        .wdata (in_value),
        .raddr (col_reg[SURF_ABITS-1:0]),
        .rdata (surf_rdata)
    );

endmodule

FILE: rtl/gcl_ram.sv
module gcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/gcl_divider.sv
module gcl_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  gcl_pkg::div_req_t req,
    output gcl_pkg::div_rsp_t rsp
);

    import gcl_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIV_N_BITS-1:0]   quo_reg, quo_next;
    logic [NH_BITS-1:0]      rem_reg, rem_next;
    logic [NH_BITS-1:0]      dvs_reg, dvs_next;
    logic [NH_BITS:0]        shifted;
    logic                    fits;

    // One quotient bit per cycle, restoring form.
    assign shifted = {rem_reg, quo_reg[DIV_N_BITS-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_N_BITS-2:0], fits};
            rem_next = fits ? NH_BITS'(shifted - {1'b0, dvs_reg}) : NH_BITS'(shifted);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(DIV_N_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: rtl/gcl_checker.sv
module gcl_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [gcl_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    input logic [gcl_pkg::IN_TUSER_BITS-1:0]  s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [gcl_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input logic                               m_axis_tuser,
    input logic                               cfg_we,
    input logic [gcl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input logic [gcl_pkg::FIELD_BITS-1:0]     cfg_data
);

    import gcl_pkg::*;

    // A stalled result keeps its valid and its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                          && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A cell number outside the grid returns all zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("out-of-grid result carries nonzero fields");

    // An accepted query keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == FN_QUERY)
        |=> !s_axis_tready)
        else $error("block ready right after a query");

    // A new result only appears after the block has been busy with a query.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a query in progress");

endmodule

bind grid_cell_locator gcl_checker u_gcl_checker (.*);
